[src/sstc_pkg.sv]
// ----------------------------------------------------------------------------
// sstc_pkg
// Shared types, opcodes, status codes and sizes of the stack shape type checker.
// ----------------------------------------------------------------------------
package sstc_pkg;

  // Type stack size and dimension width
  localparam int STACK_DEPTH = 256;
  localparam int DIM_BITS    = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = ADDR_W + 1;

  // Fixed port widths
  localparam int MODE_W  = 8;
  localparam int PORT_DIM_W = 16;
  localparam int LIMIT_W = 9;
  localparam int COUNT_W = 9;
  localparam int CMP_W   = (SP_W > LIMIT_W) ? SP_W : LIMIT_W;

  // Opcodes
  localparam logic [MODE_W-1:0] OPC_SCALAR = 8'h01;
  localparam logic [MODE_W-1:0] OPC_VECTOR = 8'h02;
  localparam logic [MODE_W-1:0] OPC_MATRIX = 8'h03;
  localparam logic [MODE_W-1:0] OPC_DUP    = 8'h04;
  localparam logic [MODE_W-1:0] OPC_SWAP   = 8'h05;
  localparam logic [MODE_W-1:0] OPC_POP    = 8'h06;
  localparam logic [MODE_W-1:0] OPC_ADD    = 8'h07;
  localparam logic [MODE_W-1:0] OPC_SUB    = 8'h08;
  localparam logic [MODE_W-1:0] OPC_MATMUL = 8'h09;
  localparam logic [MODE_W-1:0] OPC_INV    = 8'h0A;
  localparam logic [MODE_W-1:0] OPC_HALT   = 8'hFF;

  // Reset value of the stack limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVER    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_TYPE    = 3'd3,
    ST_SHAPE   = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_HALT    = 3'd6,
    ST_IGNORED = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_SCALAR = 2'd1,
    KIND_VECTOR = 2'd2,
    KIND_MATRIX = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [DIM_BITS-1:0] rows;
    logic [DIM_BITS-1:0] cols;
  } entry_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic fetch;    // read the second stack entry
    logic exec;     // apply the typing rule and post the result
  } cmd_t;

endpackage

[src/sstc_ctrl.sv]
// ----------------------------------------------------------------------------
// sstc_ctrl
// Two-state sequencer: accept a word, then execute it in the following cycle.
// ----------------------------------------------------------------------------
module sstc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output sstc_pkg::cmd_t    cmd
);

  sstc_pkg::state_t state_r;
  sstc_pkg::state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sstc_pkg::S_IDLE: begin
        if (start) state_nxt = sstc_pkg::S_EXEC;
      end
      sstc_pkg::S_EXEC: begin
        state_nxt = sstc_pkg::S_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.fetch   = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      sstc_pkg::S_IDLE: begin
        cmd.capture = start;
        cmd.fetch   = 1'b1;
      end
      sstc_pkg::S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
    endcase
  end

endmodule

[src/sstc_dp.sv]
// ----------------------------------------------------------------------------
// sstc_dp
// Type stack datapath: cached top entry, stack memory for the entries below it,
// typing rules and result registers.
// ----------------------------------------------------------------------------
module sstc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sstc_pkg::cmd_t                       cmd,
  input  logic [sstc_pkg::MODE_W-1:0]          in_mode,
  input  logic [sstc_pkg::PORT_DIM_W-1:0]      in_dim_rows,
  input  logic [sstc_pkg::PORT_DIM_W-1:0]      in_dim_cols,
  input  logic                                 cfg_we,
  input  logic [sstc_pkg::LIMIT_W-1:0]         cfg_data,
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [1:0]                           out_top_kind,
  output logic [sstc_pkg::PORT_DIM_W-1:0]      out_top_rows,
  output logic [sstc_pkg::PORT_DIM_W-1:0]      out_top_cols,
  output logic [sstc_pkg::COUNT_W-1:0]         out_stack_count,
  output logic                                 out_obligation_valid,
  output logic [sstc_pkg::PORT_DIM_W-1:0]      out_obligation_size
);

  localparam int AW = sstc_pkg::ADDR_W;
  localparam int SW = sstc_pkg::SP_W;
  localparam int CW = sstc_pkg::CMP_W;
  localparam int DW = sstc_pkg::DIM_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(sstc_pkg::STACK_DEPTH);

  // Stack memory holds every entry below the cached top
  sstc_pkg::entry_t mem [sstc_pkg::STACK_DEPTH];

  // Control state
  logic [SW-1:0]                 sp_r, sp_nxt;
  logic                          stopped_r, stopped_nxt;
  logic [sstc_pkg::LIMIT_W-1:0]  limit_r;
  logic                          out_valid_r;

  // Payload registers
  sstc_pkg::entry_t              top_r, top_nxt;
  sstc_pkg::entry_t              sec_r;
  logic [sstc_pkg::MODE_W-1:0]   mode_r;
  logic [DW-1:0]                 rows_r, cols_r;
  logic [2:0]                    status_out_r;
  logic [1:0]                    kind_out_r;
  logic [sstc_pkg::PORT_DIM_W-1:0] rows_out_r, cols_out_r, obl_size_out_r;
  logic [sstc_pkg::COUNT_W-1:0]  count_out_r;
  logic                          obl_valid_out_r;

  // Execute-stage signals
  sstc_pkg::status_t             status;
  logic                          obl_valid;
  logic [DW-1:0]                 obl_size;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  sstc_pkg::entry_t              wr_data;
  logic                          push_req;
  sstc_pkg::entry_t              push_ent;
  logic [SW-1:0]                 sp_m1, sp_m2;
  logic                          has1, has2, full;
  logic [CW-1:0]                 sp_ext, lim_ext, lim_c;

  assign sp_m1  = sp_r - SW'(1);
  assign sp_m2  = sp_r - SW'(2);
  assign has1   = (sp_r != '0);
  assign has2   = (sp_r > SW'(1));
  assign sp_ext = CW'(sp_r);
  assign lim_ext = CW'(limit_r);
  assign lim_c  = (lim_ext > DEPTH_C) ? DEPTH_C : lim_ext;
  assign full   = (sp_ext >= lim_c);

  // Latch the incoming word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      rows_r <= DW'(in_dim_rows);
      cols_r <= DW'(in_dim_cols);
    end
  end

  // Stack memory: write on execute, registered read of the second entry
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.fetch) begin
      sec_r <= mem[sp_m2[AW-1:0]];
    end
  end

  // Apply the typing rule
  always_comb begin
    status   = sstc_pkg::ST_OK;
    obl_valid = 1'b0;
    obl_size = '0;
    sp_nxt   = sp_r;
    top_nxt  = top_r;
    wr_en    = 1'b0;
    wr_addr  = sp_m1[AW-1:0];
    wr_data  = top_r;
    push_req = 1'b0;
    push_ent = top_r;

    if (stopped_r) begin
      status = sstc_pkg::ST_IGNORED;
    end else begin
      unique case (mode_r)
        sstc_pkg::OPC_SCALAR: begin
          push_req = 1'b1;
          push_ent = '{kind: sstc_pkg::KIND_SCALAR, rows: DW'(1), cols: DW'(1)};
        end
        sstc_pkg::OPC_VECTOR: begin
          push_req = 1'b1;
          push_ent = '{kind: sstc_pkg::KIND_VECTOR, rows: DW'(1), cols: cols_r};
        end
        sstc_pkg::OPC_MATRIX: begin
          push_req = 1'b1;
          push_ent = '{kind: sstc_pkg::KIND_MATRIX, rows: rows_r, cols: cols_r};
        end
        sstc_pkg::OPC_DUP: begin
          if (!has1) status = sstc_pkg::ST_UNDER;
          else push_req = 1'b1;
        end
        sstc_pkg::OPC_SWAP: begin
          if (!has2) begin
            status = sstc_pkg::ST_UNDER;
          end else begin
            wr_en   = 1'b1;
            wr_addr = sp_m2[AW-1:0];
            top_nxt = sec_r;
          end
        end
        sstc_pkg::OPC_POP: begin
          if (!has1) begin
            status = sstc_pkg::ST_UNDER;
          end else begin
            sp_nxt  = sp_m1;
            top_nxt = sec_r;
          end
        end
        sstc_pkg::OPC_ADD, sstc_pkg::OPC_SUB: begin
          if (!has2) begin
            status = sstc_pkg::ST_UNDER;
          end else if (sec_r.kind == sstc_pkg::KIND_SCALAR &&
                       top_r.kind == sstc_pkg::KIND_SCALAR) begin
            sp_nxt  = sp_m1;
            top_nxt = sec_r;
          end else if (sec_r.kind == sstc_pkg::KIND_VECTOR &&
                       top_r.kind == sstc_pkg::KIND_VECTOR) begin
            if (sec_r.rows != top_r.rows || sec_r.cols != top_r.cols) begin
              status = sstc_pkg::ST_SHAPE;
            end else begin
              sp_nxt  = sp_m1;
              top_nxt = sec_r;
            end
          end else begin
            status = sstc_pkg::ST_TYPE;
          end
        end
        sstc_pkg::OPC_MATMUL: begin
          if (!has2) begin
            status = sstc_pkg::ST_UNDER;
          end else if (sec_r.kind != sstc_pkg::KIND_MATRIX ||
                       top_r.kind != sstc_pkg::KIND_MATRIX) begin
            status = sstc_pkg::ST_TYPE;
          end else if (sec_r.cols != top_r.rows) begin
            status = sstc_pkg::ST_SHAPE;
          end else begin
            sp_nxt  = sp_m1;
            top_nxt = '{kind: sstc_pkg::KIND_MATRIX, rows: sec_r.rows, cols: top_r.cols};
          end
        end
        sstc_pkg::OPC_INV: begin
          if (!has1) begin
            status = sstc_pkg::ST_UNDER;
          end else if (top_r.kind != sstc_pkg::KIND_MATRIX) begin
            status = sstc_pkg::ST_TYPE;
          end else if (top_r.rows != top_r.cols) begin
            status = sstc_pkg::ST_SHAPE;
          end else begin
            obl_valid = 1'b1;
            obl_size  = top_r.rows;
            sp_nxt    = sp_m1;
            top_nxt   = sec_r;
          end
        end
        sstc_pkg::OPC_HALT: begin
          status = sstc_pkg::ST_HALT;
        end
        default: begin
          status = sstc_pkg::ST_UNKNOWN;
        end
      endcase

      // Push: spill the old top into memory, then cache the new entry
      if (push_req) begin
        if (full) begin
          status = sstc_pkg::ST_OVER;
        end else begin
          wr_en   = has1;
          wr_addr = sp_m1[AW-1:0];
          top_nxt = push_ent;
          sp_nxt  = sp_r + SW'(1);
        end
      end
    end

    stopped_nxt = stopped_r | (status != sstc_pkg::ST_OK);
  end

  // Control state: pointer, stop flag, limit register, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      stopped_r   <= 1'b0;
      limit_r     <= sstc_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.exec) begin
        sp_r      <= sp_nxt;
        stopped_r <= stopped_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
    end
  end

  // Hold top entry and post the result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      top_r           <= top_nxt;
      status_out_r    <= status;
      count_out_r     <= sstc_pkg::COUNT_W'(sp_nxt);
      obl_valid_out_r <= obl_valid;
      obl_size_out_r  <= sstc_pkg::PORT_DIM_W'(obl_size);
      if (sp_nxt == '0) begin
        kind_out_r <= sstc_pkg::KIND_EMPTY;
        rows_out_r <= '0;
        cols_out_r <= '0;
      end else begin
        kind_out_r <= top_nxt.kind;
        rows_out_r <= sstc_pkg::PORT_DIM_W'(top_nxt.rows);
        cols_out_r <= sstc_pkg::PORT_DIM_W'(top_nxt.cols);
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_out_r;
  assign out_top_kind         = kind_out_r;
  assign out_top_rows         = rows_out_r;
  assign out_top_cols         = cols_out_r;
  assign out_stack_count      = count_out_r;
  assign out_obligation_valid = obl_valid_out_r;
  assign out_obligation_size  = obl_size_out_r;

endmodule

[src/stack_shape_type_checker.sv]
// ----------------------------------------------------------------------------
// stack_shape_type_checker
// Each instruction word has an accept cycle, in which the
// entry under the stack top is read from the stack memory, and an execute
// cycle, in which the typing rule is applied against the cached top entry
// and that read data. busy is high during the execute cycle, and no new word
// is taken until it ends. The result word is shown on the out_
// ports for exactly one cycle, flagged by out_valid, in the cycle after the
// execute cycle; the receiver cannot stall it and must take it then. After
// reset the stack is empty and no clearing pass is needed. Write cfg_data
// (stack limit) only while no word is in flight.
// ----------------------------------------------------------------------------
module stack_shape_type_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sstc_pkg::MODE_W-1:0]      in_mode,
  input  logic [sstc_pkg::PORT_DIM_W-1:0]  in_dim_rows,
  input  logic [sstc_pkg::PORT_DIM_W-1:0]  in_dim_cols,
  input  logic                             cfg_we,
  input  logic [sstc_pkg::LIMIT_W-1:0]     cfg_data,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [1:0]                       out_top_kind,
  output logic [sstc_pkg::PORT_DIM_W-1:0]  out_top_rows,
  output logic [sstc_pkg::PORT_DIM_W-1:0]  out_top_cols,
  output logic [sstc_pkg::COUNT_W-1:0]     out_stack_count,
  output logic                             out_obligation_valid,
  output logic [sstc_pkg::PORT_DIM_W-1:0]  out_obligation_size
);

  sstc_pkg::cmd_t cmd;

  // Sequencer
  sstc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Type stack and typing rules
  sstc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_mode              (in_mode),
    .in_dim_rows          (in_dim_rows),
    .in_dim_cols          (in_dim_cols),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_top_kind         (out_top_kind),
    .out_top_rows         (out_top_rows),
    .out_top_cols         (out_top_cols),
    .out_stack_count      (out_stack_count),
    .out_obligation_valid (out_obligation_valid),
    .out_obligation_size  (out_obligation_size)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stack_shape_type_checker. Instruction words are
// planned against a shadow of the type stack so that long error-free programs
// run deep into the stack under several stack limits, with random gaps on
// start. One error of a randomly chosen kind closes the run, followed by words
// that must all be ignored. Each result word is compared field by field with
// the shadow's prediction.
// ----------------------------------------------------------------------------
module tb_top;

  // One instruction word and one result word, at the port widths
  typedef struct packed {
    logic [sstc_pkg::MODE_W-1:0]     mode;
    logic [sstc_pkg::PORT_DIM_W-1:0] rows;
    logic [sstc_pkg::PORT_DIM_W-1:0] cols;
  } instr_word_t;

  typedef struct packed {
    sstc_pkg::status_t               status;
    sstc_pkg::kind_t                 kind;
    logic [sstc_pkg::PORT_DIM_W-1:0] rows;
    logic [sstc_pkg::PORT_DIM_W-1:0] cols;
    logic [sstc_pkg::COUNT_W-1:0]    count;
    logic                            obl_valid;
    logic [sstc_pkg::PORT_DIM_W-1:0] obl_size;
  } verdict_t;

  // Shadow of the type stack, its pointer, the stop latch and the limit
  typedef struct packed {
    sstc_pkg::entry_t [sstc_pkg::STACK_DEPTH-1:0] slot;
    logic [sstc_pkg::SP_W-1:0]                    sp;
    logic                                         stopped;
    logic [sstc_pkg::LIMIT_W-1:0]                 limit;
  } shape_stack_t;

  localparam int SETTLE_CYCLES = 4;

  // Ops that grow the stack and ops that rework or shrink it
  localparam logic [sstc_pkg::MODE_W-1:0] GROW_OPS [4] =
    '{sstc_pkg::OPC_SCALAR, sstc_pkg::OPC_VECTOR, sstc_pkg::OPC_MATRIX, sstc_pkg::OPC_DUP};
  localparam logic [sstc_pkg::MODE_W-1:0] REWORK_OPS [6] =
    '{sstc_pkg::OPC_SWAP, sstc_pkg::OPC_POP, sstc_pkg::OPC_ADD, sstc_pkg::OPC_SUB,
      sstc_pkg::OPC_MATMUL, sstc_pkg::OPC_INV};

  // Random phases: stack limit, percent of idle cycles, percent of pushes, words
  localparam int NUM_PHASES       = 7;
  localparam int RAND_LIMIT_PHASE = 5;
  localparam int PHASE_LIMIT [NUM_PHASES] = '{511, 0, 1, 3, 2, 0, 256};
  localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 47, 14, 0, 47, 14, 0};
  localparam int PHASE_PUSH  [NUM_PHASES] = '{95, 0, 50, 55, 55, 50, 60};
  localparam int PHASE_WORDS [NUM_PHASES] = '{300, 260, 50, 60, 50, 50, 40};

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [sstc_pkg::MODE_W-1:0]     in_mode = '0;
  logic [sstc_pkg::PORT_DIM_W-1:0] in_dim_rows = '0;
  logic [sstc_pkg::PORT_DIM_W-1:0] in_dim_cols = '0;
  logic                            cfg_we = 1'b0;
  logic [sstc_pkg::LIMIT_W-1:0]    cfg_data = '0;
  logic                            out_valid;
  logic [2:0]                      out_status;
  logic [1:0]                      out_top_kind;
  logic [sstc_pkg::PORT_DIM_W-1:0] out_top_rows;
  logic [sstc_pkg::PORT_DIM_W-1:0] out_top_cols;
  logic [sstc_pkg::COUNT_W-1:0]    out_stack_count;
  logic                            out_obligation_valid;
  logic [sstc_pkg::PORT_DIM_W-1:0] out_obligation_size;

  instr_word_t  pending_words[$];
  verdict_t     expected_verdicts[$];
  shape_stack_t live_stack;
  shape_stack_t plan_stack;
  instr_word_t  drive_word;
  verdict_t     due_verdict;
  int           words_issued = 0;
  int           words_taken = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           idle_pct = 0;

  stack_shape_type_checker uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_dim_rows          (in_dim_rows),
    .in_dim_cols          (in_dim_cols),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_top_kind         (out_top_kind),
    .out_top_rows         (out_top_rows),
    .out_top_cols         (out_top_cols),
    .out_stack_count      (out_stack_count),
    .out_obligation_valid (out_obligation_valid),
    .out_obligation_size  (out_obligation_size)
  );

  always #5 clk = ~clk;

  // Apply one instruction to a shadow stack and return the result word
  function automatic verdict_t type_check(inout shape_stack_t s, input instr_word_t w);
    verdict_t                  v;
    sstc_pkg::status_t         st;
    sstc_pkg::entry_t          a;
    sstc_pkg::entry_t          b;
    sstc_pkg::entry_t          e;
    logic                      do_push;
    logic [sstc_pkg::SP_W-1:0] lim;
    int                        top;
    v = '0;
    st = sstc_pkg::ST_OK;
    a = '0;
    b = '0;
    e = '0;
    do_push = 1'b0;
    top = int'(s.sp) - 1;
    lim = (s.limit > sstc_pkg::SP_W'(sstc_pkg::STACK_DEPTH)) ?
          sstc_pkg::SP_W'(sstc_pkg::STACK_DEPTH) : s.limit;
    if (s.stopped) begin
      st = sstc_pkg::ST_IGNORED;
    end else begin
      case (w.mode)
        sstc_pkg::OPC_SCALAR: begin
          e.kind = sstc_pkg::KIND_SCALAR;
          e.rows = sstc_pkg::DIM_BITS'(1);
          e.cols = sstc_pkg::DIM_BITS'(1);
          do_push = 1'b1;
        end
        sstc_pkg::OPC_VECTOR: begin
          e.kind = sstc_pkg::KIND_VECTOR;
          e.rows = sstc_pkg::DIM_BITS'(1);
          e.cols = w.cols;
          do_push = 1'b1;
        end
        sstc_pkg::OPC_MATRIX: begin
          e.kind = sstc_pkg::KIND_MATRIX;
          e.rows = w.rows;
          e.cols = w.cols;
          do_push = 1'b1;
        end
        sstc_pkg::OPC_DUP: begin
          if (s.sp == 0) begin
            st = sstc_pkg::ST_UNDER;
          end else begin
            e = s.slot[top];
            do_push = 1'b1;
          end
        end
        sstc_pkg::OPC_SWAP: begin
          if (s.sp < 2) begin
            st = sstc_pkg::ST_UNDER;
          end else begin
            a = s.slot[top-1];
            s.slot[top-1] = s.slot[top];
            s.slot[top] = a;
          end
        end
        sstc_pkg::OPC_POP: begin
          if (s.sp == 0) st = sstc_pkg::ST_UNDER;
          else s.sp = s.sp - 1'b1;
        end
        sstc_pkg::OPC_ADD, sstc_pkg::OPC_SUB: begin
          if (s.sp < 2) begin
            st = sstc_pkg::ST_UNDER;
          end else begin
            a = s.slot[top-1];
            b = s.slot[top];
            if (a.kind == sstc_pkg::KIND_SCALAR && b.kind == sstc_pkg::KIND_SCALAR) begin
              s.sp = s.sp - 1'b1;
            end else if (a.kind == sstc_pkg::KIND_VECTOR &&
                         b.kind == sstc_pkg::KIND_VECTOR) begin
              if (a.rows != b.rows || a.cols != b.cols) st = sstc_pkg::ST_SHAPE;
              else s.sp = s.sp - 1'b1;
            end else begin
              st = sstc_pkg::ST_TYPE;
            end
          end
        end
        sstc_pkg::OPC_MATMUL: begin
          if (s.sp < 2) begin
            st = sstc_pkg::ST_UNDER;
          end else begin
            a = s.slot[top-1];
            b = s.slot[top];
            if (a.kind != sstc_pkg::KIND_MATRIX || b.kind != sstc_pkg::KIND_MATRIX) begin
              st = sstc_pkg::ST_TYPE;
            end else if (a.cols != b.rows) begin
              st = sstc_pkg::ST_SHAPE;
            end else begin
              s.slot[top-1].cols = b.cols;
              s.sp = s.sp - 1'b1;
            end
          end
        end
        sstc_pkg::OPC_INV: begin
          if (s.sp == 0) begin
            st = sstc_pkg::ST_UNDER;
          end else begin
            a = s.slot[top];
            if (a.kind != sstc_pkg::KIND_MATRIX) begin
              st = sstc_pkg::ST_TYPE;
            end else if (a.rows != a.cols) begin
              st = sstc_pkg::ST_SHAPE;
            end else begin
              v.obl_valid = 1'b1;
              v.obl_size = a.rows;
              s.sp = s.sp - 1'b1;
            end
          end
        end
        sstc_pkg::OPC_HALT: st = sstc_pkg::ST_HALT;
        default: st = sstc_pkg::ST_UNKNOWN;
      endcase
      // Push only below the effective limit
      if (do_push) begin
        if (s.sp >= lim) begin
          st = sstc_pkg::ST_OVER;
        end else begin
          s.slot[s.sp] = e;
          s.sp = s.sp + 1'b1;
        end
      end
      if (st != sstc_pkg::ST_OK) s.stopped = 1'b1;
    end
    v.status = st;
    v.count = s.sp;
    if (s.sp != 0) begin
      e = s.slot[int'(s.sp) - 1];
      v.kind = e.kind;
      v.rows = e.rows;
      v.cols = e.cols;
    end
    return v;
  endfunction

  // True when the op would pass the type rules on this stack
  function automatic bit is_safe(shape_stack_t s, logic [sstc_pkg::MODE_W-1:0] op);
    sstc_pkg::entry_t          a;
    sstc_pkg::entry_t          b;
    logic [sstc_pkg::SP_W-1:0] lim;
    a = '0;
    b = '0;
    lim = (s.limit > sstc_pkg::SP_W'(sstc_pkg::STACK_DEPTH)) ?
          sstc_pkg::SP_W'(sstc_pkg::STACK_DEPTH) : s.limit;
    if (s.sp != 0) b = s.slot[int'(s.sp) - 1];
    if (s.sp >= 2) a = s.slot[int'(s.sp) - 2];
    case (op)
      sstc_pkg::OPC_SCALAR, sstc_pkg::OPC_VECTOR, sstc_pkg::OPC_MATRIX: return s.sp < lim;
      sstc_pkg::OPC_DUP:  return s.sp != 0 && s.sp < lim;
      sstc_pkg::OPC_SWAP: return s.sp >= 2;
      sstc_pkg::OPC_POP:  return s.sp != 0;
      sstc_pkg::OPC_ADD, sstc_pkg::OPC_SUB:
        return s.sp >= 2 &&
               ((a.kind == sstc_pkg::KIND_SCALAR && b.kind == sstc_pkg::KIND_SCALAR) ||
                (a.kind == sstc_pkg::KIND_VECTOR && a == b));
      sstc_pkg::OPC_MATMUL:
        return s.sp >= 2 && a.kind == sstc_pkg::KIND_MATRIX &&
               b.kind == sstc_pkg::KIND_MATRIX && a.cols == b.rows;
      sstc_pkg::OPC_INV:
        return s.sp != 0 && b.kind == sstc_pkg::KIND_MATRIX && b.rows == b.cols;
      default: return 1'b0;
    endcase
  endfunction

  // Mostly small dimensions so shapes line up; sometimes the edges or anything
  function automatic logic [sstc_pkg::PORT_DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return sstc_pkg::PORT_DIM_W'($urandom);
    return sstc_pkg::PORT_DIM_W'($urandom_range(1, 4));
  endfunction

  // Fill in dimensions, often matching the top so that combining ops apply
  function automatic instr_word_t shape_word(shape_stack_t s,
                                             logic [sstc_pkg::MODE_W-1:0] op);
    instr_word_t      w;
    sstc_pkg::entry_t t;
    t = '0;
    w.mode = op;
    w.rows = sstc_pkg::PORT_DIM_W'($urandom);
    w.cols = sstc_pkg::PORT_DIM_W'($urandom);
    if (s.sp != 0) t = s.slot[int'(s.sp) - 1];
    if (op == sstc_pkg::OPC_VECTOR) begin
      w.cols = (t.kind == sstc_pkg::KIND_VECTOR && $urandom_range(0, 1) == 1) ?
               t.cols : pick_dim();
    end else if (op == sstc_pkg::OPC_MATRIX) begin
      w.rows = (t.kind == sstc_pkg::KIND_MATRIX && $urandom_range(0, 1) == 1) ?
               t.cols : pick_dim();
      w.cols = ($urandom_range(0, 1) == 1) ? w.rows : pick_dim();
    end
    return w;
  endfunction

  // Choose a legal word; found drops when the stack admits no legal op
  function automatic instr_word_t next_word(shape_stack_t s, int push_pct, output bit found);
    logic [sstc_pkg::MODE_W-1:0] op;
    int                          n;
    found = 1'b1;
    for (n = 0; n < 32; n++) begin
      if ($urandom_range(0, 99) < push_pct) op = GROW_OPS[$urandom_range(0, 3)];
      else op = REWORK_OPS[$urandom_range(0, 5)];
      if (is_safe(s, op)) return shape_word(s, op);
    end
    foreach (REWORK_OPS[i]) if (is_safe(s, REWORK_OPS[i])) return shape_word(s, REWORK_OPS[i]);
    foreach (GROW_OPS[i]) if (is_safe(s, GROW_OPS[i])) return shape_word(s, GROW_OPS[i]);
    found = 1'b0;
    return '0;
  endfunction

  task automatic report_mismatch(input string detail);
    mismatches++;
    $display("ERROR: %s", detail);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  // Advance the plan and hand the word to the driver
  task automatic enqueue(input logic [sstc_pkg::MODE_W-1:0] mode,
                         input logic [sstc_pkg::PORT_DIM_W-1:0] rows,
                         input logic [sstc_pkg::PORT_DIM_W-1:0] cols);
    instr_word_t w;
    w = '{mode, rows, cols};
    void'(type_check(plan_stack, w));
    pending_words.push_back(w);
  endtask

  // Hold until every word is taken and answered, then let the pipe empty
  task automatic wait_settled();
    while (pending_words.size() != 0 || words_issued != words_taken ||
           expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [sstc_pkg::LIMIT_W-1:0] value);
    wait_settled();
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk) cfg_we <= 1'b0;
    @(posedge clk);
    plan_stack.limit = value;
  endtask

  // Driver: hold a word until taken, then issue the next one or idle
  always @(negedge clk) begin
    if (rst_n && words_taken == words_issued) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drive_word = pending_words.pop_front();
        start <= 1'b1;
        in_mode <= drive_word.mode;
        in_dim_rows <= drive_word.rows;
        in_dim_cols <= drive_word.cols;
        words_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: track the limit, check result words, predict each taken word
  always @(posedge clk) begin
    if (!rst_n) begin
      live_stack = '0;
      live_stack.limit = sstc_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we) live_stack.limit = cfg_data;
      if (out_valid) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    results_seen));
        end else begin
          due_verdict = expected_verdicts.pop_front();
          check_field("status", out_status, due_verdict.status);
          check_field("top_kind", out_top_kind, due_verdict.kind);
          check_field("top_rows", out_top_rows, due_verdict.rows);
          check_field("top_cols", out_top_cols, due_verdict.cols);
          check_field("stack_count", out_stack_count, due_verdict.count);
          check_field("obligation_valid", out_obligation_valid, due_verdict.obl_valid);
          check_field("obligation_size", out_obligation_size, due_verdict.obl_size);
        end
        results_seen++;
      end
      if (start && !busy) begin
        expected_verdicts.push_back(type_check(live_stack,
                                               '{in_mode, in_dim_rows, in_dim_cols}));
        words_taken++;
      end
    end
  end

  // Stimulus
  initial begin
    int                           p;
    int                           n;
    bit                           found;
    instr_word_t                  w;
    sstc_pkg::status_t            fault;
    logic [sstc_pkg::MODE_W-1:0]  op;
    logic [sstc_pkg::LIMIT_W-1:0] lim_value;
    plan_stack = '0;
    plan_stack.limit = sstc_pkg::LIMIT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // Directed program: scalars, vectors and matrices at the dimension edges
    enqueue(sstc_pkg::OPC_SCALAR, '1, '1);
    enqueue(sstc_pkg::OPC_SCALAR, '0, '0);
    enqueue(sstc_pkg::OPC_ADD, '0, '0);
    enqueue(sstc_pkg::OPC_DUP, '1, '0);
    enqueue(sstc_pkg::OPC_SUB, '0, '1);
    enqueue(sstc_pkg::OPC_POP, '0, '0);                 // empty stack reports zero top
    enqueue(sstc_pkg::OPC_VECTOR, 16'h1234, '1);
    enqueue(sstc_pkg::OPC_DUP, '0, '0);
    enqueue(sstc_pkg::OPC_ADD, '0, '0);
    enqueue(sstc_pkg::OPC_VECTOR, '1, '0);
    enqueue(sstc_pkg::OPC_VECTOR, '0, '0);
    enqueue(sstc_pkg::OPC_SUB, '0, '0);
    enqueue(sstc_pkg::OPC_SWAP, '0, '0);
    enqueue(sstc_pkg::OPC_POP, '0, '0);
    enqueue(sstc_pkg::OPC_POP, '0, '0);
    enqueue(sstc_pkg::OPC_MATRIX, 16'd3, '1);
    enqueue(sstc_pkg::OPC_MATRIX, '1, 16'd2);
    enqueue(sstc_pkg::OPC_MATMUL, '0, '0);
    enqueue(sstc_pkg::OPC_MATRIX, 16'd2, 16'd3);
    enqueue(sstc_pkg::OPC_MATMUL, '0, '0);
    enqueue(sstc_pkg::OPC_INV, '0, '0);
    enqueue(sstc_pkg::OPC_MATRIX, '1, '1);
    enqueue(sstc_pkg::OPC_DUP, '0, '0);
    enqueue(sstc_pkg::OPC_INV, '0, '0);
    enqueue(sstc_pkg::OPC_MATRIX, '0, '0);              // zero-size square matrix
    enqueue(sstc_pkg::OPC_INV, '0, '0);
    enqueue(sstc_pkg::OPC_INV, '0, '0);

    // Random error-free programs under several stack limits
    for (p = 0; p < NUM_PHASES; p++) begin
      lim_value = (p == RAND_LIMIT_PHASE) ? sstc_pkg::LIMIT_W'($urandom_range(4, 40))
                                          : sstc_pkg::LIMIT_W'(PHASE_LIMIT[p]);
      write_limit(lim_value);
      idle_pct = PHASE_IDLE[p];
      for (n = 0; n < PHASE_WORDS[p]; n++) begin
        w = next_word(plan_stack, PHASE_PUSH[p], found);
        if (!found) break;
        enqueue(w.mode, w.rows, w.cols);
      end
    end

    // Close with one error of a random kind, then words that must be ignored
    fault = sstc_pkg::status_t'($urandom_range(sstc_pkg::ST_OVER, sstc_pkg::ST_HALT));
    idle_pct = PHASE_IDLE[2];
    write_limit(sstc_pkg::LIMIT_W'(9'h1FF));
    while (plan_stack.sp > 6) enqueue(sstc_pkg::OPC_POP, '0, '0);
    case (fault)
      sstc_pkg::ST_OVER: begin
        write_limit(sstc_pkg::LIMIT_W'(plan_stack.sp));
        enqueue(GROW_OPS[$urandom_range(0, 2)], sstc_pkg::PORT_DIM_W'($urandom),
                sstc_pkg::PORT_DIM_W'($urandom));
      end
      sstc_pkg::ST_UNDER: begin
        while (plan_stack.sp != 0) enqueue(sstc_pkg::OPC_POP, '0, '0);
        op = ($urandom_range(0, 1) == 1) ? sstc_pkg::OPC_DUP
                                         : REWORK_OPS[$urandom_range(0, 5)];
        enqueue(op, '0, '0);
      end
      sstc_pkg::ST_TYPE: begin
        enqueue(sstc_pkg::OPC_MATRIX, 16'd2, 16'd2);
        enqueue(sstc_pkg::OPC_SCALAR, '0, '0);
        enqueue(REWORK_OPS[$urandom_range(2, 5)], '0, '0);
      end
      sstc_pkg::ST_SHAPE: begin
        case ($urandom_range(0, 2))
          0: begin
            enqueue(sstc_pkg::OPC_MATRIX, 16'd2, 16'd3);
            enqueue(sstc_pkg::OPC_INV, '0, '0);
          end
          1: begin
            enqueue(sstc_pkg::OPC_MATRIX, 16'd2, 16'd3);
            enqueue(sstc_pkg::OPC_MATRIX, 16'd2, 16'd3);
            enqueue(sstc_pkg::OPC_MATMUL, '0, '0);
          end
          default: begin
            enqueue(sstc_pkg::OPC_VECTOR, '0, 16'd3);
            enqueue(sstc_pkg::OPC_VECTOR, '0, 16'd5);
            enqueue(($urandom_range(0, 1) == 1) ? sstc_pkg::OPC_ADD : sstc_pkg::OPC_SUB,
                    '0, '0);
          end
        endcase
      end
      sstc_pkg::ST_UNKNOWN: begin
        // Draw until the byte is not a listed opcode; near values come often
        do begin
          op = sstc_pkg::MODE_W'($urandom_range(0, ($urandom_range(0, 1) == 1) ? 15 : 254));
        end while ((op >= sstc_pkg::OPC_SCALAR && op <= sstc_pkg::OPC_INV) ||
                   op == sstc_pkg::OPC_HALT);
        enqueue(op, sstc_pkg::PORT_DIM_W'($urandom), sstc_pkg::PORT_DIM_W'($urandom));
      end
      default: enqueue(sstc_pkg::OPC_HALT, sstc_pkg::PORT_DIM_W'($urandom),
                       sstc_pkg::PORT_DIM_W'($urandom));
    endcase
    repeat (24) enqueue(sstc_pkg::MODE_W'($urandom), sstc_pkg::PORT_DIM_W'($urandom),
                        sstc_pkg::PORT_DIM_W'($urandom));

    wait_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
